/* rtl/ppm_input_decoder_unit_macros.svh */
// Assertion helpers for the decoder datapath.
// Each helper samples on the rising edge of clk and is disabled while rst_n is low.
`ifndef PPM_INPUT_DECODER_UNIT_MACROS_SVH
`define PPM_INPUT_DECODER_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Consequent must hold in the same cycle as the antecedent.
`define PPM_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ppm_input_decoder_unit: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define PPM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ppm_input_decoder_unit: next-cycle check failed");

`else

`define PPM_ASSERT_IMPL(label, ante, cons)
`define PPM_ASSERT_NEXT(label, ante, cons)

`endif

`endif

/* rtl/ppm_id_pkg.sv */
package ppm_id_pkg;

  // Number of channel slots that may be written while locked.
  localparam int MAX_CHANNELS = 16;

  // Field widths.
  localparam int CAP_W     = 16;
  localparam int CFG_W     = 12;
  localparam int THR_W     = 16;
  localparam int CNT_W     = 8;
  localparam int IDX_W     = 4;
  localparam int VAL_W     = 32;
  localparam int APB_AW    = 4;
  localparam int APB_DW    = 32;
  localparam int OUT_DW    = 48;
  localparam int OUT_UW    = 4;

  // Conversion arithmetic: (t - 2*centre) * 10000 / (2*delta).
  localparam int DIFF_W    = 18;
  localparam int PROD_W    = 32;
  localparam int MAG_W     = 30;
  localparam int DEN_W     = 13;
  localparam int DIV_CNT_W = 5;
  localparam logic signed [15:0] SCALE = 16'sd10000;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;
  localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

  // Register reset values.
  localparam logic [CFG_W-1:0] CENTER_RST   = 12'd1500;
  localparam logic [CFG_W-1:0] DELTA_RST    = 12'd500;
  localparam logic [THR_W-1:0] SYNC_THR_RST = 16'd6600;

  // Register indexes on the configuration port (word address).
  typedef enum logic [1:0] {
    REG_CENTER   = 2'd0,
    REG_DELTA    = 2'd1,
    REG_SYNC_THR = 2'd2
  } cfg_reg_t;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_LOAD,
    ST_DIV,
    ST_DONE
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic mul_en;
    logic div_start;
    logic load_out;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic need_div;
    logic div_busy;
    logic out_free;
  } status_t;

endpackage

/* rtl/ppm_input_decoder_unit.sv */
// Channel   | Direction | Beat contents
// in_       | sink      | tdata[15:0] edge_capture
// out_      | source    | tdata channel_count, channel_index, channel_value; tuser flags;
//           |           | tlast frame_end
// cfg_      | APB slave | 0x0 center_pulse_us, 0x4 delta_pulse_us, 0x8 sync_threshold
//
// An edge that writes a channel is multiplied, then starts the divider and waits while its
// 30 steps run and finish, and is then loaded into the output register. The next edge is
// taken only in the cycle after the load. Any other edge goes straight to the load.
// A finished beat waits in the output register while the next edge is accepted;
// a full output register holds the controller in its final state.
// Reset is synchronous and active low; it restores the register defaults and unlocks.
module ppm_input_decoder_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  // edge_capture [15:0]
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [ppm_id_pkg::CAP_W-1:0]  in_tdata,
  // channel_count [7:0], channel_index [11:8], channel_value [43:12], zero [47:44]
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [ppm_id_pkg::OUT_DW-1:0] out_tdata,
  // in_sync [0], value_written [1], sync_acquired [2], sync_lost [3]
  output logic [ppm_id_pkg::OUT_UW-1:0] out_tuser,
  output logic                          out_tlast,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [ppm_id_pkg::APB_AW-1:0] cfg_paddr,
  input  logic [ppm_id_pkg::APB_DW-1:0] cfg_pwdata,
  output logic [ppm_id_pkg::APB_DW-1:0] cfg_prdata,
  output logic                          cfg_pready
);
  import ppm_id_pkg::*;

  logic [CFG_W-1:0] center_r, center_nxt;
  logic [CFG_W-1:0] delta_r, delta_nxt;
  logic [THR_W-1:0] thr_r, thr_nxt;
  logic             cfg_wr;
  cfg_reg_t         cfg_sel;
  cmd_t             cmd;
  status_t          status;

  // Register file on the configuration port.
  always_comb begin
    cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
    cfg_sel    = cfg_reg_t'(cfg_paddr[3:2]);
    center_nxt = center_r;
    delta_nxt  = delta_r;
    thr_nxt    = thr_r;
    cfg_prdata = '0;
    unique case (cfg_sel)
      REG_CENTER: begin
        cfg_prdata = {{(APB_DW-CFG_W){1'b0}}, center_r};
        if (cfg_wr) begin
          center_nxt = cfg_pwdata[CFG_W-1:0];
        end
      end
      REG_DELTA: begin
        cfg_prdata = {{(APB_DW-CFG_W){1'b0}}, delta_r};
        if (cfg_wr) begin
          delta_nxt = cfg_pwdata[CFG_W-1:0];
        end
      end
      REG_SYNC_THR: begin
        cfg_prdata = {{(APB_DW-THR_W){1'b0}}, thr_r};
        if (cfg_wr) begin
          thr_nxt = cfg_pwdata[THR_W-1:0];
        end
      end
      default: cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_r <= CENTER_RST;
      delta_r  <= DELTA_RST;
      thr_r    <= SYNC_THR_RST;
    end else begin
      center_r <= center_nxt;
      delta_r  <= delta_nxt;
      thr_r    <= thr_nxt;
    end
  end

  assign cfg_pready = 1'b1;

  ppm_id_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  ppm_id_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .status          (status),
    .edge_capture    (in_tdata),
    .center_pulse_us (center_r),
    .delta_pulse_us  (delta_r),
    .sync_threshold  (thr_r),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .out_tuser       (out_tuser),
    .out_tlast       (out_tlast)
  );

endmodule

/* rtl/ppm_id_div.sv */
module ppm_id_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [ppm_id_pkg::MAG_W-1:0] dividend,
  input  logic [ppm_id_pkg::DEN_W-1:0] divisor,
  output logic                         busy,
  output logic [ppm_id_pkg::MAG_W-1:0] quotient
);
  import ppm_id_pkg::*;

  logic                 busy_r, busy_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [MAG_W-1:0]     quo_r, quo_nxt;
  logic [DEN_W-1:0]     rem_r, rem_nxt;
  logic [DEN_W-1:0]     dsr_r, dsr_nxt;
  logic [DEN_W:0]       trial;
  logic [DEN_W:0]       trial_sub;
  logic                 fits;

  // One restoring step: bring down the next dividend bit and try a subtract.
  always_comb begin
    trial     = {rem_r, quo_r[MAG_W-1]};
    trial_sub = trial - {1'b0, dsr_r};
    fits      = trial >= {1'b0, dsr_r};
  end

  // Iteration control and shift registers.
  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = DIV_CNT_W'(MAG_W - 1);
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dsr_nxt  = divisor;
    end else if (busy_r) begin
      quo_nxt = {quo_r[MAG_W-2:0], fits};
      rem_nxt = fits ? trial_sub[DEN_W-1:0] : trial[DEN_W-1:0];
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
      end else begin
        cnt_nxt = cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign busy     = busy_r;
  assign quotient = quo_r;

endmodule

/* rtl/ppm_id_dp.sv */
`include "ppm_input_decoder_unit_macros.svh"

module ppm_id_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  ppm_id_pkg::cmd_t              cmd,
  output ppm_id_pkg::status_t           status,
  input  logic [ppm_id_pkg::CAP_W-1:0]  edge_capture,
  input  logic [ppm_id_pkg::CFG_W-1:0]  center_pulse_us,
  input  logic [ppm_id_pkg::CFG_W-1:0]  delta_pulse_us,
  input  logic [ppm_id_pkg::THR_W-1:0]  sync_threshold,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [ppm_id_pkg::OUT_DW-1:0] out_tdata,
  output logic [ppm_id_pkg::OUT_UW-1:0] out_tuser,
  output logic                          out_tlast
);
  import ppm_id_pkg::*;

  // Decoder tracking state.
  logic [CAP_W-1:0] last_r, last_nxt;
  logic             locked_r, locked_nxt;
  logic [1:0]       frame_r, frame_nxt;
  logic [CNT_W-1:0] counts_r [4];
  logic [CNT_W-1:0] counts_nxt [4];
  logic [CNT_W-1:0] found_r, found_nxt;
  logic [CNT_W-1:0] nextch_r, nextch_nxt;

  // Per-beat evaluation at the accepting edge.
  logic [CAP_W-1:0] interval;
  logic             gap;
  logic             written;
  logic             acquired;
  logic             lost;
  logic [IDX_W-1:0] idx;
  logic [1:0]       frame_inc;
  logic [CNT_W-1:0] nextch_inc;
  logic [CNT_W-1:0] last_slot;

  // Result held while the value is converted.
  logic [CAP_W-1:0] t_r;
  logic             res_sync_r;
  logic [CNT_W-1:0] res_count_r;
  logic             res_written_r;
  logic [IDX_W-1:0] res_idx_r;
  logic             res_acq_r;
  logic             res_lost_r;
  logic             res_gap_r;

  // Conversion path.
  logic signed [DIFF_W-1:0] diff;
  logic signed [PROD_W-1:0] prod_nxt;
  logic signed [PROD_W-1:0] prod_r;
  logic [PROD_W-1:0]        prod_mag;
  logic                     div_busy;
  logic [MAG_W-1:0]         quotient;
  logic [VAL_W-1:0]         quo_ext;
  logic [VAL_W-1:0]         value;

  // Output register.
  logic             out_valid_r, out_valid_nxt;
  logic             out_sync_r;
  logic [CNT_W-1:0] out_count_r;
  logic             out_written_r;
  logic [IDX_W-1:0] out_idx_r;
  logic [VAL_W-1:0] out_value_r;
  logic             out_acq_r;
  logic             out_lost_r;
  logic             out_gap_r;

  // Interval to the previous edge and the frame tracking update.
  always_comb begin
    interval   = edge_capture - last_r;
    gap        = interval > sync_threshold;
    frame_inc  = frame_r + 2'd1;
    nextch_inc = (nextch_r == CNT_MAX) ? CNT_MAX : nextch_r + 1'b1;
    last_slot  = (nextch_r == CNT_MAX) ? CNT_MAX - 1'b1 : nextch_r;
    written    = 1'b0;
    acquired   = 1'b0;
    lost       = 1'b0;
    idx        = '0;
    last_nxt   = edge_capture;
    locked_nxt = locked_r;
    frame_nxt  = frame_r;
    counts_nxt = counts_r;
    found_nxt  = found_r;
    nextch_nxt = nextch_r;
    if (!locked_r) begin
      if (gap) begin
        if (frame_r != 2'd3) begin
          frame_nxt             = frame_inc;
          counts_nxt[frame_inc] = '0;
        end else begin
          frame_nxt     = 2'd0;
          counts_nxt[0] = '0;
          // Lock when frames one and two saw the same count of two or more.
          if (counts_r[1] > 8'd1 && counts_r[1] == counts_r[2]) begin
            found_nxt  = counts_r[1];
            locked_nxt = 1'b1;
            acquired   = 1'b1;
            nextch_nxt = '0;
          end
        end
      end else if (counts_r[frame_r] != CNT_MAX) begin
        counts_nxt[frame_r] = counts_r[frame_r] + 1'b1;
      end
    end else begin
      written    = nextch_r < CNT_W'(MAX_CHANNELS);
      idx        = written ? nextch_r[IDX_W-1:0] : '0;
      nextch_nxt = nextch_inc;
      if (gap) begin
        // A sync gap after the wrong number of channels drops the lock.
        if (last_slot != found_r) begin
          locked_nxt = 1'b0;
          lost       = 1'b1;
        end
        nextch_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r   <= '0;
      locked_r <= 1'b0;
      frame_r  <= '0;
      counts_r <= '{default: '0};
      found_r  <= '0;
      nextch_r <= '0;
    end else if (cmd.accept) begin
      last_r   <= last_nxt;
      locked_r <= locked_nxt;
      frame_r  <= frame_nxt;
      counts_r <= counts_nxt;
      found_r  <= found_nxt;
      nextch_r <= nextch_nxt;
    end
  end

  // Hold the flags of the beat until its value is ready.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      t_r           <= interval;
      res_sync_r    <= locked_nxt;
      res_count_r   <= found_nxt;
      res_written_r <= written;
      res_idx_r     <= idx;
      res_acq_r     <= acquired;
      res_lost_r    <= lost;
      res_gap_r     <= gap;
    end
  end

  // Scaled numerator, registered before the divider.
  always_comb begin
    diff     = signed'({2'b00, t_r}) - signed'({5'b00000, center_pulse_us, 1'b0});
    prod_nxt = diff * SCALE;
    prod_mag = prod_r[PROD_W-1] ? PROD_W'(-prod_r) : PROD_W'(prod_r);
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod_r <= prod_nxt;
    end
  end

  ppm_id_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (prod_mag[MAG_W-1:0]),
    .divisor  ({delta_pulse_us, 1'b0}),
    .busy     (div_busy),
    .quotient (quotient)
  );

  // Apply the sign; a zero divisor saturates a nonzero numerator by sign.
  always_comb begin
    quo_ext = {{(VAL_W-MAG_W){1'b0}}, quotient};
    if (!res_written_r) begin
      value = '0;
    end else if (delta_pulse_us == '0) begin
      if (prod_r[PROD_W-1]) begin
        value = VAL_MIN;
      end else if (prod_r == '0) begin
        value = '0;
      end else begin
        value = VAL_MAX;
      end
    end else if (prod_r[PROD_W-1]) begin
      value = -quo_ext;
    end else begin
      value = quo_ext;
    end
  end

  // Output register: loaded by the controller, emptied by the sink.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_sync_r    <= res_sync_r;
      out_count_r   <= res_count_r;
      out_written_r <= res_written_r;
      out_idx_r     <= res_idx_r;
      out_value_r   <= value;
      out_acq_r     <= res_acq_r;
      out_lost_r    <= res_lost_r;
      out_gap_r     <= res_gap_r;
    end
  end

  assign status.need_div = locked_r && (nextch_r < CNT_W'(MAX_CHANNELS));
  assign status.div_busy = div_busy;
  assign status.out_free = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DW-VAL_W-IDX_W-CNT_W){1'b0}}, out_value_r, out_idx_r, out_count_r};
  assign out_tuser  = {out_lost_r, out_acq_r, out_written_r, out_sync_r};
  assign out_tlast  = out_gap_r;

  // Acquiring lock happens only while unlocked, so no value goes with it.
  `PPM_ASSERT_IMPL(a_acq_no_write, out_valid_r && out_acq_r, out_sync_r && !out_written_r)
  // Losing lock needs a sync gap and leaves the decoder unlocked.
  `PPM_ASSERT_IMPL(a_lost_on_gap, out_valid_r && out_lost_r, out_gap_r && !out_sync_r)
  // A beat without a channel write carries a zero index and value.
  `PPM_ASSERT_IMPL(a_idle_payload, out_valid_r && !out_written_r,
                   out_value_r == '0 && out_idx_r == '0)
  // The divider is running in the cycle after it is started.
  `PPM_ASSERT_NEXT(a_div_runs, cmd.div_start, div_busy)

endmodule

/* rtl/ppm_id_ctrl.sv */
module ppm_id_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  ppm_id_pkg::status_t status,
  output ppm_id_pkg::cmd_t    cmd
);
  import ppm_id_pkg::*;

  state_t state_r, state_nxt;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = status.need_div ? ST_MUL : ST_DONE;
        end
      end
      ST_MUL:  state_nxt = ST_LOAD;
      ST_LOAD: state_nxt = ST_DIV;
      ST_DIV: begin
        if (!status.div_busy) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (status.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Outputs.
  always_comb begin
    in_tready     = 1'b0;
    cmd           = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready  = 1'b1;
        cmd.accept = in_tvalid;
      end
      ST_MUL:  cmd.mul_en    = 1'b1;
      ST_LOAD: cmd.div_start = 1'b1;
      ST_DIV:  cmd           = '0;
      ST_DONE: cmd.load_out  = status.out_free;
      default: cmd           = '0;
    endcase
  end

endmodule
